// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the checkers of this block.
// Both sample on the rising edge of aclk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define NYD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked at every edge, during reset too.
`define NYD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/core/nyd_pkg.sv -----
package nyd_pkg;

    // Command codes carried by s_command
    localparam logic CMD_CONVERT = 1'b0;
    localparam logic CMD_WRITE   = 1'b1;

    // Table slot map
    localparam logic [5:0] I_BASE   = 6'd16;
    localparam logic [5:0] Q_BASE   = 6'd28;
    localparam logic [5:0] SLOT_END = 6'd40;

    localparam int LUMA_ENTRIES = 16;
    localparam int CHROMA_ROWS  = 4;
    localparam int CHANNELS     = 3;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] CHAN_MAX     = 8'hFF;

    // Format mode codes
    localparam logic MODE_YIQ8    = 1'b0;
    localparam logic MODE_AYIQ844 = 1'b1;

    typedef struct packed {
        logic [1:0] row;
        logic [1:0] ch;
    } chroma_pos_t;

    // One table write, already decoded to its memory
    typedef struct packed {
        logic              luma_we;
        logic              i_we;
        logic              q_we;
        logic [3:0]        addr;   // luma index, or chroma row in [1:0]
        logic [1:0]        ch;
        logic signed [8:0] value;
    } tbl_wr_t;

    // Registered read data for one texel
    typedef struct packed {
        logic [7:0]      luma;
        logic [2:0][8:0] i_val;
        logic [2:0][8:0] q_val;
    } tbl_rd_t;

    // Chroma offset (slot minus base, 0..11) to row and channel
    function automatic chroma_pos_t chroma_pos(input logic [3:0] offset);
        chroma_pos_t pos;
        if (offset < 4'd3) begin
            pos.row = 2'd0;
            pos.ch  = offset[1:0];
        end else if (offset < 4'd6) begin
            pos.row = 2'd1;
            pos.ch  = 2'(offset - 4'd3);
        end else if (offset < 4'd9) begin
            pos.row = 2'd2;
            pos.ch  = 2'(offset - 4'd6);
        end else begin
            pos.row = 2'd3;
            pos.ch  = 2'(offset - 4'd9);
        end
        return pos;
    endfunction

endpackage

// ----- rtl/core/nyd_table.sv -----
// Decode table: one luma memory and one small memory per chroma channel,
// so each texel reads every memory at a single address.
module nyd_table (
    input  logic              aclk,
    input  nyd_pkg::tbl_wr_t  wr,
    input  logic              rd_en,
    input  logic [3:0]        rd_luma_idx,
    input  logic [1:0]        rd_i_row,
    input  logic [1:0]        rd_q_row,
    output nyd_pkg::tbl_rd_t  rd_data
);

    logic [7:0]        luma_mem [nyd_pkg::LUMA_ENTRIES];
    logic signed [8:0] i_mem    [nyd_pkg::CHANNELS][nyd_pkg::CHROMA_ROWS];
    logic signed [8:0] q_mem    [nyd_pkg::CHANNELS][nyd_pkg::CHROMA_ROWS];

    nyd_pkg::tbl_rd_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.luma_we) begin
            luma_mem[wr.addr] <= wr.value[7:0];
        end
        if (rd_en) begin
            rd_data_reg.luma <= luma_mem[rd_luma_idx];
        end
        for (int c = 0; c < nyd_pkg::CHANNELS; c++) begin
            if (wr.i_we && wr.ch == 2'(c)) begin
                i_mem[c][wr.addr[1:0]] <= wr.value;
            end
            if (wr.q_we && wr.ch == 2'(c)) begin
                q_mem[c][wr.addr[1:0]] <= wr.value;
            end
            if (rd_en) begin
                rd_data_reg.i_val[c] <= i_mem[c][rd_i_row];
                rd_data_reg.q_val[c] <= q_mem[c][rd_q_row];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/ncc_yiq_texel_decoder.sv -----
// NCC (YIQ 4:2:2) texel decoder. Each input word is either a table write
// (s_command high: slot 0-15 luma, 16-27 I, 28-39 Q, others dropped) or a
// texel to convert (s_command low). A converted texel yields one 32-bit
// color word {alpha, blue, green, red}; each channel is luma + I + Q clamped
// to 0..255, and alpha is 0xFF, or texel[15:8] when format_mode is 1.
// Throughput is one word per cycle for writes and converts alike, mixed in
// any order, while the output is not stalled. Two register stages: the table
// read register loads at the edge that accepts the texel, and the add/clamp
// loads the output register from it once that register is empty or being
// drained; the color word then shows on m_color_word.
// Table entries power up undefined and are not cleared;
// load every entry a texel will use before converting. format_mode may be
// changed only while no texel is in flight.
module ncc_yiq_texel_decoder (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    // input words
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic [15:0]        s_texel,
    input  logic [5:0]         s_table_slot,
    input  logic signed [8:0]  s_table_value,
    input  logic               s_last_texel,
    // result words
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_color_word,
    output logic               m_last_pixel
);

    // Configuration
    logic format_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_mode_reg <= nyd_pkg::MODE_YIQ8;
        end else if (cfg_wr_en) begin
            format_mode_reg <= cfg_wr_data;
        end
    end

    // Handshake and pipeline control
    logic s_accept;
    logic out_free;
    logic s1_free;

    logic s1_valid_reg, s1_valid_next;
    logic m_valid_reg,  m_valid_next;

    assign out_free = !m_valid_reg || m_ready;
    // Stage 1 moves whenever it is empty or the output register can take its word,
    // so a new word enters stage 1 while a finished color waits only if stage 1 is empty.
    assign s1_free  = !s1_valid_reg || out_free;
    assign s_ready  = s1_free;
    assign s_accept = s_valid && s_ready;

    // Table write decode. Each word is either a write or a convert, so a texel's read
    // never meets a write to the same entry in the same cycle; a write lands at
    // its accept edge and the next texel already reads the new value.
    nyd_pkg::tbl_wr_t    tbl_wr;
    nyd_pkg::chroma_pos_t i_pos;
    nyd_pkg::chroma_pos_t q_pos;
    logic                is_write;

    assign is_write = s_accept && (s_command == nyd_pkg::CMD_WRITE);
    assign i_pos    = nyd_pkg::chroma_pos(4'(s_table_slot - nyd_pkg::I_BASE));
    assign q_pos    = nyd_pkg::chroma_pos(4'(s_table_slot - nyd_pkg::Q_BASE));

    always_comb begin
        tbl_wr.luma_we = is_write && (s_table_slot < nyd_pkg::I_BASE);
        tbl_wr.i_we    = is_write && (s_table_slot >= nyd_pkg::I_BASE)
                                  && (s_table_slot < nyd_pkg::Q_BASE);
        tbl_wr.q_we    = is_write && (s_table_slot >= nyd_pkg::Q_BASE)
                                  && (s_table_slot < nyd_pkg::SLOT_END);
        tbl_wr.value   = s_table_value;
        priority if (s_table_slot < nyd_pkg::I_BASE) begin
            tbl_wr.addr = s_table_slot[3:0];
            tbl_wr.ch   = 2'd0;
        end else if (s_table_slot < nyd_pkg::Q_BASE) begin
            tbl_wr.addr = {2'b00, i_pos.row};
            tbl_wr.ch   = i_pos.ch;
        end else begin
            tbl_wr.addr = {2'b00, q_pos.row};
            tbl_wr.ch   = q_pos.ch;
        end
    end

    // Table memories; the read register doubles as stage 1 data
    nyd_pkg::tbl_rd_t tbl_rd;

    nyd_table u_table (
        .aclk        (aclk),
        .wr          (tbl_wr),
        .rd_en       (s1_free),
        .rd_luma_idx (s_texel[7:4]),
        .rd_i_row    (s_texel[3:2]),
        .rd_q_row    (s_texel[1:0]),
        .rd_data     (tbl_rd)
    );

    // Stage 1 side data: alpha and block-end flag travel with the read
    logic [7:0] s1_alpha_reg, s1_alpha_next;
    logic       s1_last_reg,  s1_last_next;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_alpha_next = s1_alpha_reg;
        s1_last_next  = s1_last_reg;
        if (s1_free) begin
            s1_valid_next = s_accept && (s_command == nyd_pkg::CMD_CONVERT);
            s1_alpha_next = (format_mode_reg == nyd_pkg::MODE_AYIQ844) ?
                            s_texel[15:8] : nyd_pkg::ALPHA_OPAQUE;
            s1_last_next  = s_last_texel;
        end
    end

    // Sum and clamp per channel: 8-bit unsigned luma plus two signed 9-bit
    // chroma terms fits in 11 signed bits.
    function automatic logic [7:0] clamp_sum(input logic signed [10:0] sum);
        logic [7:0] res;
        priority if (sum[10]) begin
            res = 8'd0;
        end else if (sum[9:8] != 2'b00) begin
            res = nyd_pkg::CHAN_MAX;
        end else begin
            res = sum[7:0];
        end
        return res;
    endfunction

    logic [2:0][7:0] chan;

    always_comb begin
        for (int c = 0; c < nyd_pkg::CHANNELS; c++) begin
            chan[c] = clamp_sum($signed({3'b000, tbl_rd.luma})
                                + 11'($signed(tbl_rd.i_val[c]))
                                + 11'($signed(tbl_rd.q_val[c])));
        end
    end

    // Output register: load when empty or being drained
    logic [31:0] m_color_reg, m_color_next;
    logic        m_last_reg,  m_last_next;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_color_next = m_color_reg;
        m_last_next  = m_last_reg;
        if (out_free) begin
            m_valid_next = s1_valid_reg;
            m_color_next = {s1_alpha_reg, chan[2], chan[1], chan[0]};
            m_last_next  = s1_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_alpha_reg <= s1_alpha_next;
        s1_last_reg  <= s1_last_next;
        m_color_reg  <= m_color_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_color_word = m_color_reg;
    assign m_last_pixel = m_last_reg;

endmodule

// ----- rtl/core/nyd_checker.sv -----
`include "assert_macros.svh"

module nyd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_command,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_color_word,
    input logic        m_last_pixel
);

    // Hold a stalled result word
    `NYD_ASSERT(a_m_valid_hold, m_valid && !m_ready |=> m_valid, "m_valid dropped while stalled")
    `NYD_ASSERT(a_m_data_hold, m_valid && !m_ready |=> $stable(m_color_word) && $stable(m_last_pixel), "m_ data changed while stalled")

    // Input stalls only when the output word is stuck
    `NYD_ASSERT(a_ready_stall, !s_ready |-> m_valid && !m_ready, "s_ready low without output back-pressure")

    // A fresh result follows an accepted convert word, through the table read register and the output register
    `NYD_ASSERT(a_result_src, $rose(m_valid) |-> $past(s_valid && s_ready && (s_command == nyd_pkg::CMD_CONVERT), 2), "result without a convert two cycles before")

    // Reset empties the output
    `NYD_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "m_valid set after reset")

endmodule

bind ncc_yiq_texel_decoder nyd_checker u_nyd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_command    (s_command),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_color_word (m_color_word),
    .m_last_pixel (m_last_pixel)
);
